/* rtl/twwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twwl_pkg
// Shared types, character codes, register indexes and saturating helpers
// for the greedy word wrap line breaker.
// ----------------------------------------------------------------------------
package twwl_pkg;

    localparam int TWWL_MAX_TEXT_LEN = 65536;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] CFG_WRAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SINGLE_LINE = 2'd1;
    localparam logic [1:0] CFG_LINE_HEIGHT = 2'd2;

    localparam logic [7:0]  LINE_HEIGHT_RST = 8'd16;
    localparam logic [19:0] WIDTH_MAX       = 20'hFFFFF;
    localparam logic [23:0] HEIGHT_MAX      = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] wrap_width;
        logic        single_line;
        logic [7:0]  line_height;
    } cfg_t;

    // Width-fixed part of the line state.
    typedef struct packed {
        logic [19:0] run_width;
        logic        space_seen;
        logic [19:0] width_before_space;
        logic [19:0] width_after_space;
        logic        prev_was_space;
        logic        skip_linefeed;
        logic [19:0] widest_line;
        logic [23:0] height_sum;
    } acc_t;

    typedef struct packed {
        logic [15:0] line_begin;
        logic [15:0] line_end;
        logic [19:0] line_width;
        logic [19:0] max_width;
        logic [23:0] total_height;
    } rec_t;

    function automatic logic [19:0] sat_add20(input logic [19:0] a, input logic [7:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {13'd0, b};
        return s[20] ? WIDTH_MAX : s[19:0];
    endfunction

    function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [7:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[24] ? HEIGHT_MAX : s[23:0];
    endfunction

endpackage

/* rtl/text_word_wrap_line_breaker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_word_wrap_line_breaker
// Greedy word wrap over a stream of characters with glyph widths. Emits one
// line record per finished line, with running maximum width and height.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  cfg      in         cfg_wr_en            cfg_addr, cfg_wdata
//  s_       in         s_valid / s_ready    char_code, glyph_width, end_of_text
//  m_       out        m_valid / m_ready    line record fields, is_last
//
//  A character is taken into an input register and worked combinationally;
//  its line records (zero to three) land in a three-entry result register,
//  from which the first record is offered. The result register drains one
//  record per cycle while m_ready is high; an item yielding several records
//  occupies it until all are taken, so the sustained rate is one item per
//  cycle while items yield at most one record each and m_ready stays high.
//  Reset is synchronous and clears all line state.
// ----------------------------------------------------------------------------
module text_word_wrap_line_breaker
    import twwl_pkg::*;
#(
    parameter int MAX_TEXT_LEN = TWWL_MAX_TEXT_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_glyph_width,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_line_begin,
    output logic [15:0] m_line_end,
    output logic [19:0] m_line_width,
    output logic [19:0] m_max_width,
    output logic [23:0] m_total_height,
    output logic        m_is_last
);

    localparam int POS_W = $clog2(MAX_TEXT_LEN);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_code_reg;
    logic [7:0]       in_width_reg;
    logic             in_eot_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] ls_reg, ls_next;
    logic [POS_W-1:0] sp_reg, sp_next;
    acc_t             acc_reg, acc_next;
    rec_t             slot_reg [3];
    rec_t             recs [3];
    logic [1:0]       cnt_reg;
    logic [1:0]       rec_count;
    logic             take;

    twwl_step #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .POS_W        (POS_W)
    ) u_step (
        .cfg             (cfg_reg),
        .char_code       (in_code_reg),
        .glyph_width     (in_width_reg),
        .end_of_text     (in_eot_reg),
        .pos             (pos_reg),
        .line_start      (ls_reg),
        .space_pos       (sp_reg),
        .acc             (acc_reg),
        .pos_next        (pos_next),
        .line_start_next (ls_next),
        .space_pos_next  (sp_next),
        .acc_next        (acc_next),
        .recs            (recs),
        .rec_count       (rec_count)
    );

    // The held item moves on once the result register is empty or emptying.
    assign take    = in_valid_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready));
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_width  <= '0;
            cfg_reg.single_line <= 1'b0;
            cfg_reg.line_height <= LINE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WRAP_WIDTH:  cfg_reg.wrap_width  <= cfg_wdata;
                CFG_SINGLE_LINE: cfg_reg.single_line <= cfg_wdata[0];
                CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_code_reg  <= s_char_code;
            in_width_reg <= s_glyph_width;
            in_eot_reg   <= s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ls_reg  <= '0;
            sp_reg  <= '0;
            acc_reg <= '0;
        end else if (take) begin
            pos_reg <= pos_next;
            ls_reg  <= ls_next;
            sp_reg  <= sp_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take) begin
            cnt_reg <= rec_count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            slot_reg[0] <= recs[0];
            slot_reg[1] <= recs[1];
            slot_reg[2] <= recs[2];
        end else if (m_valid && m_ready) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign m_valid        = (cnt_reg != 2'd0);
    assign m_is_last      = (cnt_reg == 2'd1);
    assign m_line_begin   = slot_reg[0].line_begin;
    assign m_line_end     = slot_reg[0].line_end;
    assign m_line_width   = slot_reg[0].line_width;
    assign m_max_width    = slot_reg[0].max_width;
    assign m_total_height = slot_reg[0].total_height;

    // The running maximum always covers the line it is reported with.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_max_width >= m_line_width))
        else $error("max_width below line_width");

    // A record that is not the last of its item is followed by another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_is_last) |=> m_valid)
        else $error("records of one item lost");

    // The end of a text returns position and totals to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && in_eot_reg) |=> (pos_reg == '0 && acc_reg.widest_line == '0
                                  && acc_reg.height_sum == '0))
        else $error("text state not cleared at end of text");

endmodule

/* rtl/twwl_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twwl_step
// Next-state and line-record logic for one character: line feed and carriage
// return handling, greedy fit test, break at the last space or mid-word, and
// the end-of-text flush. Produces up to three ordered line records.
// ----------------------------------------------------------------------------
module twwl_step
    import twwl_pkg::*;
#(
    parameter int MAX_TEXT_LEN = TWWL_MAX_TEXT_LEN,
    parameter int POS_W        = $clog2(MAX_TEXT_LEN)
) (
    input  cfg_t             cfg,
    input  logic [7:0]       char_code,
    input  logic [7:0]       glyph_width,
    input  logic             end_of_text,
    input  logic [POS_W-1:0] pos,
    input  logic [POS_W-1:0] line_start,
    input  logic [POS_W-1:0] space_pos,
    input  acc_t             acc,
    output logic [POS_W-1:0] pos_next,
    output logic [POS_W-1:0] line_start_next,
    output logic [POS_W-1:0] space_pos_next,
    output acc_t             acc_next,
    output rec_t             recs [3],
    output logic [1:0]       rec_count
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_TEXT_LEN - 1);

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [15:0] low16(input logic [POS_W-1:0] p);
        logic [POS_W+15:0] t;
        t = {16'd0, p};
        return t[15:0];
    endfunction

    logic [POS_W-1:0] ni;
    logic [POS_W-1:0] ls;
    logic [POS_W-1:0] spv;
    logic [19:0]      run;
    logic             ss;
    logic [19:0]      wbs;
    logic [19:0]      was;
    logic             pws;
    logic             skip;
    logic [19:0]      carry;
    logic             fits;
    logic             e1, e2, e3;
    rec_t             r1, r2, r3;
    rec_t             slot [3];
    logic [19:0]      wm;
    logic [23:0]      hs;

    always_comb begin
        ni    = next_pos(pos);
        ls    = line_start;
        spv   = space_pos;
        run   = acc.run_width;
        ss    = acc.space_seen;
        wbs   = acc.width_before_space;
        was   = acc.width_after_space;
        pws   = acc.prev_was_space;
        skip  = acc.skip_linefeed;
        carry = '0;
        fits  = 1'b1;
        e1    = 1'b0;
        e2    = 1'b0;
        e3    = 1'b0;
        r1    = '0;
        r2    = '0;
        r3    = '0;

        if (cfg.single_line) begin
            skip = 1'b0;
            run  = sat_add20(run, glyph_width);
        end else if (acc.skip_linefeed && char_code == CH_LF) begin
            // Second half of a CR-LF pair: the line was already closed.
            skip = 1'b0;
            ls = ni; run = '0; ss = 1'b0; spv = '0; wbs = '0; was = '0; pws = 1'b0;
        end else begin
            skip = 1'b0;
            if (char_code == CH_LF || char_code == CH_CR) begin
                e1 = 1'b1;
                r1.line_begin = low16(ls);
                r1.line_end   = low16(pos);
                r1.line_width = run;
                ls = ni; run = '0; ss = 1'b0; spv = '0; wbs = '0; was = '0; pws = 1'b0;
                skip = (char_code == CH_CR);
            end else begin
                fits = (({1'b0, run} + {13'd0, glyph_width}) <= {5'd0, cfg.wrap_width})
                       || (pos == ls);
                if (!fits && char_code == CH_SPACE) begin
                    // An overflowing space closes the line and is dropped.
                    e1 = 1'b1;
                    r1.line_begin = low16(ls);
                    r1.line_end   = low16(pos);
                    r1.line_width = run;
                    ls = ni; run = '0; ss = 1'b0; spv = '0; wbs = '0; was = '0; pws = 1'b0;
                end else begin
                    if (!fits) begin
                        if (ss) begin
                            // Break at the last space; the partial word moves down.
                            carry = was;
                            e1 = 1'b1;
                            r1.line_begin = low16(ls);
                            r1.line_end   = low16(spv);
                            r1.line_width = wbs;
                            ls = next_pos(spv);
                            run = carry; was = carry;
                            ss = 1'b0; spv = '0; wbs = '0; pws = 1'b0;
                            fits = (({1'b0, carry} + {13'd0, glyph_width})
                                    <= {5'd0, cfg.wrap_width}) || (pos == ls);
                        end
                        if (!fits) begin
                            // Mid-word break: this character opens the next line.
                            if (e1) begin
                                e2 = 1'b1;
                                r2.line_begin = low16(ls);
                                r2.line_end   = low16(pos);
                                r2.line_width = run;
                            end else begin
                                e1 = 1'b1;
                                r1.line_begin = low16(ls);
                                r1.line_end   = low16(pos);
                                r1.line_width = run;
                            end
                            ls = pos; run = '0; ss = 1'b0; spv = '0; wbs = '0;
                            was = '0; pws = 1'b0;
                        end
                    end
                    if (char_code == CH_SPACE) begin
                        ss  = 1'b1;
                        spv = pos;
                        wbs = run;
                        was = '0;
                        pws = 1'b1;
                    end else begin
                        was = sat_add20(was, glyph_width);
                        pws = 1'b0;
                    end
                    run = sat_add20(run, glyph_width);
                end
            end
        end

        if (end_of_text) begin
            e3 = cfg.single_line || (ls != ni);
            r3.line_begin = low16(ls);
            r3.line_end   = low16(ni);
            r3.line_width = run;
            pos_next = '0;
            skip = 1'b0;
            ls = '0; run = '0; ss = 1'b0; spv = '0; wbs = '0; was = '0; pws = 1'b0;
        end else begin
            pos_next = ni;
        end

        rec_count = {1'b0, e1} + {1'b0, e2} + {1'b0, e3};

        // Pack the records in emission order.
        slot[0] = e1 ? r1 : r3;
        slot[1] = e2 ? r2 : r3;
        slot[2] = r3;

        wm = acc.widest_line;
        hs = acc.height_sum;
        for (int k = 0; k < 3; k++) begin
            recs[k] = slot[k];
            if (2'(k) < rec_count) begin
                if (slot[k].line_width > wm) begin
                    wm = slot[k].line_width;
                end
                hs = sat_add24(hs, cfg.line_height);
            end
            recs[k].max_width    = wm;
            recs[k].total_height = hs;
        end

        line_start_next             = ls;
        space_pos_next              = spv;
        acc_next.run_width          = run;
        acc_next.space_seen         = ss;
        acc_next.width_before_space = wbs;
        acc_next.width_after_space  = was;
        acc_next.prev_was_space     = pws;
        acc_next.skip_linefeed      = skip;
        acc_next.widest_line        = end_of_text ? '0 : wm;
        acc_next.height_sum         = end_of_text ? '0 : hs;
    end

endmodule

/* test/text_word_wrap_line_breaker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_word_wrap_line_breaker_tb
// Self-checking bench for the greedy word wrap line breaker. Characters are
// sent in random bursts while the result side stalls on its own pattern.
// A behavioral line breaker inside the bench predicts every line record,
// and each record coming out is checked field by field.
// ----------------------------------------------------------------------------
module text_word_wrap_line_breaker_tb;
    import twwl_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        rec_t rec;
        logic last;
    } line_exp_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_addr       = CFG_WRAP_WIDTH;
    logic [15:0] cfg_wdata      = 16'd0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code    = 8'd0;
    logic [7:0]  s_glyph_width  = 8'd0;
    logic        s_end_of_text  = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_line_begin;
    logic [15:0] m_line_end;
    logic [19:0] m_line_width;
    logic [19:0] m_max_width;
    logic [23:0] m_total_height;
    logic        m_is_last;

    text_word_wrap_line_breaker dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_glyph_width  (s_glyph_width),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_begin   (m_line_begin),
        .m_line_end     (m_line_end),
        .m_line_width   (m_line_width),
        .m_max_width    (m_max_width),
        .m_total_height (m_total_height),
        .m_is_last      (m_is_last)
    );

    always #5 aclk = ~aclk;

    // Register copies and line state of the predictor.
    logic [15:0] wrap_cfg   = 16'd0;
    logic        single_cfg = 1'b0;
    logic [7:0]  height_cfg = LINE_HEIGHT_RST;

    logic [15:0] pos        = 16'd0;
    logic [15:0] ln_begin   = 16'd0;
    logic [19:0] ln_width   = 20'd0;
    logic [15:0] sp_pos     = 16'd0;
    logic        sp_seen    = 1'b0;
    logic [19:0] w_pre_sp   = 20'd0;
    logic [19:0] w_post_sp  = 20'd0;
    logic        lf_skip    = 1'b0;
    logic [19:0] widest     = 20'd0;
    logic [23:0] height_acc = 24'd0;

    line_exp_t step_lines[$];
    line_exp_t expected_lines[$];

    int errors        = 0;
    int chars_sent    = 0;
    int texts_sent    = 0;
    int lines_checked = 0;
    int burst_left    = 0;
    int rx_mode       = 0;
    int rx_run        = 0;

    // ------------------------------------------------------------------
    // Line breaker predictor
    // ------------------------------------------------------------------
    function automatic logic [19:0] add_sat20(input logic [19:0] a, input logic [7:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {13'd0, b};
        return (s > 21'h0FFFFF) ? 20'hFFFFF : s[19:0];
    endfunction

    function automatic void record_line(input logic [15:0] first, input logic [15:0] stop,
                                        input logic [19:0] wid);
        logic [24:0] h;
        line_exp_t   e;
        if (wid > widest)
            widest = wid;
        h = {1'b0, height_acc} + {17'd0, height_cfg};
        height_acc = h[24] ? 24'hFFFFFF : h[23:0];
        e.rec.line_begin   = first;
        e.rec.line_end     = stop;
        e.rec.line_width   = wid;
        e.rec.max_width    = widest;
        e.rec.total_height = height_acc;
        e.last             = 1'b0;
        step_lines.push_back(e);
    endfunction

    function automatic void open_line(input logic [15:0] first);
        ln_begin  = first;
        ln_width  = 20'd0;
        sp_seen   = 1'b0;
        sp_pos    = 16'd0;
        w_pre_sp  = 20'd0;
        w_post_sp = 20'd0;
    endfunction

    function automatic logic fits(input logic [7:0] wid, input logic [15:0] idx);
        return (({1'b0, ln_width} + {13'd0, wid}) <= {5'd0, wrap_cfg}) || (idx == ln_begin);
    endfunction

    function automatic void place_char(input logic [7:0] code, input logic [7:0] wid,
                                       input logic [15:0] idx);
        logic        room;
        logic [19:0] carry;
        room = fits(wid, idx);
        if (!room) begin
            // An overflowing space closes the line and is dropped.
            if (code == CH_SPACE) begin
                record_line(ln_begin, idx, ln_width);
                open_line(idx + 16'd1);
                return;
            end
            // Break at the last space; the partial word moves down.
            if (sp_seen) begin
                carry = w_post_sp;
                record_line(ln_begin, sp_pos, w_pre_sp);
                open_line(sp_pos + 16'd1);
                ln_width  = carry;
                w_post_sp = carry;
                room      = fits(wid, idx);
            end
            if (!room) begin
                record_line(ln_begin, idx, ln_width);
                open_line(idx);
            end
        end
        if (code == CH_SPACE) begin
            sp_seen   = 1'b1;
            sp_pos    = idx;
            w_pre_sp  = ln_width;
            w_post_sp = 20'd0;
        end else begin
            w_post_sp = add_sat20(w_post_sp, wid);
        end
        ln_width = add_sat20(ln_width, wid);
    endfunction

    function automatic void predict_char(input logic [7:0] code, input logic [7:0] wid,
                                         input logic eot);
        logic [15:0] idx;
        logic [15:0] nxt;
        idx = pos;
        nxt = pos + 16'd1;
        step_lines.delete();
        if (single_cfg) begin
            lf_skip  = 1'b0;
            ln_width = add_sat20(ln_width, wid);
        end else if (lf_skip && code == CH_LF) begin
            lf_skip = 1'b0;
            open_line(nxt);
        end else begin
            lf_skip = 1'b0;
            if (code == CH_LF) begin
                record_line(ln_begin, idx, ln_width);
                open_line(nxt);
            end else if (code == CH_CR) begin
                record_line(ln_begin, idx, ln_width);
                open_line(nxt);
                lf_skip = 1'b1;
            end else begin
                place_char(code, wid, idx);
            end
        end
        if (eot) begin
            if (single_cfg || ln_begin != nxt)
                record_line(ln_begin, nxt, ln_width);
            pos        = 16'd0;
            lf_skip    = 1'b0;
            widest     = 20'd0;
            height_acc = 24'd0;
            open_line(16'd0);
        end else begin
            pos = nxt;
        end
        if (step_lines.size() > 0)
            step_lines[step_lines.size() - 1].last = 1'b1;
        foreach (step_lines[k])
            expected_lines.push_back(step_lines[k]);
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and record check
    // ------------------------------------------------------------------
    task automatic compare_field(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic check_record();
        line_exp_t e;
        if (expected_lines.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected line record, expected none, actual begin %0d end %0d",
                         $time, m_line_begin, m_line_end);
        end else begin
            e = expected_lines.pop_front();
            compare_field("line_begin", 24'(e.rec.line_begin), 24'(m_line_begin));
            compare_field("line_end", 24'(e.rec.line_end), 24'(m_line_end));
            compare_field("line_width", 24'(e.rec.line_width), 24'(m_line_width));
            compare_field("max_width", 24'(e.rec.max_width), 24'(m_max_width));
            compare_field("total_height", e.rec.total_height, m_total_height);
            compare_field("is_last", 24'(e.last), 24'(m_is_last));
            lines_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_record();
        // The receiver alternates between free flow, random stalls and heavy stalls.
        if (rx_run == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_run  = $urandom_range(4, 40);
        end
        rx_run--;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] code, input logic [7:0] wid, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_char_code   <= code;
        s_glyph_width <= wid;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_char(code, wid, eot);
        chars_sent++;
        if (eot)
            texts_sent++;
    endtask

    task automatic send_text(input string txt, input logic [7:0] wid, input logic eot);
        for (int k = 0; k < txt.len(); k++)
            send_char(txt[k], wid, eot && (k == txt.len() - 1));
    endtask

    // Waits until every expected record is out and the pipeline is empty.
    task automatic quiesce();
        s_valid    <= 1'b0;
        burst_left  = 0;
        @(posedge aclk);
        while (expected_lines.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] wrap, input logic single,
                              input logic [7:0] height);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_WRAP_WIDTH;
        cfg_wdata <= wrap;
        @(posedge aclk);
        cfg_addr  <= CFG_SINGLE_LINE;
        cfg_wdata <= {15'd0, single};
        @(posedge aclk);
        cfg_addr  <= CFG_LINE_HEIGHT;
        cfg_wdata <= {8'd0, height};
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        wrap_cfg   = wrap;
        single_cfg = single;
        height_cfg = height;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: zero wrap width puts every letter on a line of its own and drops the space.
    task automatic test_reset_values();
        send_text("ab c", 8'd7, 1'b1);
    endtask

    task automatic test_line_endings();
        set_config(16'd200, 1'b0, 8'd20);
        // Leading LF, CR-LF pair, CR followed by CR, CR followed by a letter.
        send_text("\nab\r\ncd\r\rx\n", 8'd9, 1'b1);
        send_text("ef\r", 8'd3, 1'b1);
    endtask

    task automatic test_wrap_rules();
        set_config(16'd10, 1'b0, 8'd1);
        // Break at the space, then mid-word, then end of text: three lines in one step.
        send_char("a", 8'd5, 1'b0);
        send_char(" ", 8'd1, 1'b0);
        send_char("b", 8'd4, 1'b0);
        send_char("c", 8'd9, 1'b1);
        // A space that overflows closes the line and is dropped.
        send_char("a", 8'd6, 1'b0);
        send_char("b", 8'd4, 1'b0);
        send_char(" ", 8'd3, 1'b0);
        send_char("c", 8'd2, 1'b1);
        // The first character always fits, even when wider than the line.
        send_char(8'hFF, 8'hFF, 1'b1);
        // A word with no space splits mid-word.
        send_text("wxyz", 8'd4, 1'b0);
        send_char(8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_single_line();
        set_config(16'd0, 1'b1, 8'd255);
        send_text("a \r\nb\n", 8'd255, 1'b1);
        send_char("q", 8'd1, 1'b1);
        // Mode switches in the middle of a text keep the running line.
        set_config(16'd30, 1'b0, 8'd10);
        send_text("ab ", 8'd8, 1'b0);
        set_config(16'd30, 1'b1, 8'd10);
        send_text("c\rd", 8'd8, 1'b0);
        set_config(16'd30, 1'b0, 8'd10);
        send_text("\ne fg", 8'd8, 1'b1);
    endtask

    task automatic test_wide_glyphs();
        // Maximum-width glyphs summed on one line, then words at full wrap width.
        set_config(16'hFFFF, 1'b1, 8'd255);
        for (int k = 0; k < 40; k++)
            send_char("m", 8'd255, k == 39);
        set_config(16'hFFFF, 1'b0, 8'd255);
        for (int k = 0; k < 40; k++)
            send_char((k % 7 == 6) ? CH_SPACE : 8'h6D, 8'd255, k == 39);
    endtask

    task automatic test_random(input int per_phase);
        int          kind;
        logic [15:0] wrap;
        logic        single;
        logic [7:0]  height;
        logic        eot;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       begin wrap = 16'd0;  single = 1'b0; height = 8'd0;   end
                1:       begin wrap = 16'hFFFF; single = 1'b0; height = 8'd255; end
                2:       begin wrap = 16'($urandom_range(10, 60)); single = 1'b0;
                               height = 8'($urandom_range(0, 255)); end
                3:       begin wrap = 16'($urandom_range(1, 300)); single = 1'b0;
                               height = 8'($urandom_range(0, 255)); end
                4:       begin wrap = 16'($urandom_range(0, 65535)); single = 1'b1;
                               height = 8'($urandom_range(0, 255)); end
                default: begin wrap = 16'($urandom_range(5, 40)); single = 1'b0;
                               height = 8'($urandom_range(0, 255)); end
            endcase
            set_config(wrap, single, height);
            for (int k = 0; k < per_phase; k++) begin
                kind = $urandom_range(0, 99);
                eot  = (k == per_phase - 1) || ($urandom_range(0, 29) == 0);
                if (kind < 58)
                    send_char(8'(8'h61 + $urandom_range(0, 25)), 8'($urandom_range(1, 12)),
                              eot);
                else if (kind < 74)
                    send_char(CH_SPACE, 8'($urandom_range(0, 8)), eot);
                else if (kind < 79)
                    send_char(CH_LF, 8'($urandom_range(0, 255)), eot);
                else if (kind < 84)
                    send_char(CH_CR, 8'($urandom_range(0, 255)), eot);
                else if (kind < 88) begin
                    send_char(CH_CR, 8'($urandom_range(0, 3)), 1'b0);
                    send_char(CH_LF, 8'($urandom_range(0, 3)), eot);
                end else if (kind < 95)
                    send_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), eot);
                else
                    send_char(8'(8'h41 + $urandom_range(0, 25)),
                              8'($urandom_range(128, 255)), eot);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        quiesce();
        test_reset_values();
        test_line_endings();
        test_wrap_rules();
        test_single_line();
        test_wide_glyphs();
        test_random(60);
        quiesce();
        $display("Sent %0d characters in %0d texts over directed and six random settings;",
                 chars_sent, texts_sent);
        $display("checked %0d line records, %0d mismatches.", lines_checked, errors);
        if (errors == 0 && expected_lines.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run under the heaviest receiver stalls.
    initial begin
        #2000000;
        $display("Timeout with %0d line records still expected.", expected_lines.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/twwl_pkg.sv
rtl/twwl_step.sv
rtl/text_word_wrap_line_breaker.sv
test/text_word_wrap_line_breaker_tb.sv
